// ----- rtl/afx_pkg.sv -----
// Shared types, opcodes and helpers for the ALU execute block.
package afx_pkg;

    localparam int REG_COUNT = 8;
    localparam int REG_IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    typedef logic [7:0]           data_t;
    typedef logic [REG_IDX_W-1:0] reg_idx_t;
    typedef logic [4:0]           mode_t;
    typedef logic [3:0]           mask_t;

    typedef struct packed {
        logic o;
        logic c;
        logic s;
        logic z;
    } flags_t;

    localparam mode_t MODE_CLR     = 5'd0;
    localparam mode_t MODE_MOV     = 5'd1;
    localparam mode_t MODE_AND     = 5'd2;
    localparam mode_t MODE_OR      = 5'd3;
    localparam mode_t MODE_XOR     = 5'd4;
    localparam mode_t MODE_ADD     = 5'd5;
    localparam mode_t MODE_ADC     = 5'd6;
    localparam mode_t MODE_SUB     = 5'd7;
    localparam mode_t MODE_SBB     = 5'd8;
    localparam mode_t MODE_TEST    = 5'd9;
    localparam mode_t MODE_INC     = 5'd10;
    localparam mode_t MODE_DEC     = 5'd11;
    localparam mode_t MODE_NOT     = 5'd12;
    localparam mode_t MODE_NEG     = 5'd13;
    localparam mode_t MODE_RND     = 5'd14;
    localparam mode_t MODE_SHL     = 5'd15;
    localparam mode_t MODE_SHR     = 5'd16;
    localparam mode_t MODE_SAR     = 5'd17;
    localparam mode_t MODE_RCL     = 5'd18;
    localparam mode_t MODE_RCR     = 5'd19;
    localparam mode_t MODE_LOADIMM = 5'd20;

    localparam data_t LFSR_RESET = 8'hE1;
    localparam data_t SIGN_BIT   = 8'h80;

    localparam int RED_W = REG_IDX_W + 1;

    function automatic reg_idx_t reg_reduce(input logic [2:0] idx);
        logic [RED_W+2:0] v;
        v = (RED_W+3)'(idx);
        for (int i = 0; i < 8; i++) begin
            if (v >= (RED_W+3)'(REG_COUNT)) begin
                v = v - (RED_W+3)'(REG_COUNT);
            end
        end
        return v[REG_IDX_W-1:0];
    endfunction

endpackage

// ----- rtl/afx_regfile.sv -----
// Register file memory with two registered read ports, write bypass and reset-to-zero valid bits.
module afx_regfile
    import afx_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     rd_en,
    input  reg_idx_t rd_a_idx,
    input  reg_idx_t rd_b_idx,
    output data_t    rd_a_data,
    output data_t    rd_b_data,
    input  logic     wr_en,
    input  reg_idx_t wr_idx,
    input  data_t    wr_data
);

    data_t                rf_mem [REG_COUNT];
    logic [REG_COUNT-1:0] vld_reg;
    logic [REG_COUNT-1:0] vld_next;
    data_t                rd_a_reg;
    data_t                rd_b_reg;
    logic                 rd_a_vld_reg;
    logic                 rd_b_vld_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (wr_en)
        begin
            vld_next[wr_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rf_mem[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_a_reg <= (wr_en && (wr_idx == rd_a_idx)) ? wr_data : rf_mem[rd_a_idx];
            rd_b_reg <= (wr_en && (wr_idx == rd_b_idx)) ? wr_data : rf_mem[rd_b_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            rd_a_vld_reg <= 1'b0;
            rd_b_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
            if (rd_en)
            begin
                rd_a_vld_reg <= vld_next[rd_a_idx];
                rd_b_vld_reg <= vld_next[rd_b_idx];
            end
        end
    end

    assign rd_a_data = rd_a_vld_reg ? rd_a_reg : '0;
    assign rd_b_data = rd_b_vld_reg ? rd_b_reg : '0;

endmodule

// ----- rtl/afx_alu.sv -----
// Combinational ALU: result, masked flag update and random source step.
module afx_alu
    import afx_pkg::*;
(
    input  mode_t  mode,
    input  data_t  va,
    input  data_t  vb,
    input  mask_t  flag_mask,
    input  data_t  imm_value,
    input  flags_t flags_in,
    input  data_t  lfsr_in,
    output data_t  result,
    output flags_t flags_out,
    output data_t  lfsr_out
);

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_ADD  = 2'd1;
    localparam logic [1:0] KIND_SUB  = 2'd2;
    localparam logic [1:0] KIND_SHR  = 2'd3;

    logic [1:0] kind;
    data_t      y;
    data_t      lfsr_step;
    logic       carry;
    logic       ovf;

    assign lfsr_step = {lfsr_in[0] ^ lfsr_in[2] ^ lfsr_in[3] ^ lfsr_in[5], lfsr_in[7:1]};
    assign lfsr_out  = (mode == MODE_RND) ? lfsr_step : lfsr_in;

    always_comb
    begin
        kind   = KIND_NONE;
        y      = vb;
        carry  = 1'b0;
        result = '0;
        unique case (mode)
            MODE_MOV: result = vb;
            MODE_AND: result = va & vb;
            MODE_OR:  result = va | vb;
            MODE_XOR: result = va ^ vb;
            MODE_ADD:
            begin
                kind            = KIND_ADD;
                {carry, result} = {1'b0, va} + {1'b0, vb};
            end
            MODE_ADC:
            begin
                kind            = KIND_ADD;
                {carry, result} = {1'b0, va} + {1'b0, vb} + {8'h00, flags_in.c};
            end
            MODE_SUB:
            begin
                kind            = KIND_SUB;
                {carry, result} = {1'b0, va} - {1'b0, vb};
            end
            MODE_SBB:
            begin
                kind            = KIND_SUB;
                {carry, result} = {1'b0, va} - {1'b0, vb} - {8'h00, flags_in.c};
            end
            MODE_TEST:
            begin
                kind   = KIND_SUB;
                y      = '0;
                result = va;
            end
            MODE_INC:
            begin
                kind            = KIND_ADD;
                y               = 8'h01;
                {carry, result} = {1'b0, va} + 9'd1;
            end
            MODE_DEC:
            begin
                kind            = KIND_SUB;
                y               = 8'h01;
                {carry, result} = {1'b0, va} - 9'd1;
            end
            MODE_NOT: result = ~va;
            MODE_NEG:
            begin
                kind   = KIND_SUB;
                y      = '0;
                result = va | SIGN_BIT;
            end
            MODE_RND: result = lfsr_step;
            MODE_SHL:
            begin
                kind   = KIND_ADD;
                y      = va;
                result = {va[6:0], 1'b0};
                carry  = va[7];
            end
            MODE_SHR:
            begin
                kind   = KIND_SHR;
                result = {1'b0, va[7:1]};
                carry  = va[0];
            end
            MODE_SAR:
            begin
                kind   = KIND_SHR;
                result = {va[7], va[7:1]};
                carry  = va[0];
            end
            MODE_RCL:
            begin
                kind   = KIND_ADD;
                y      = va;
                result = {va[6:0], flags_in.c};
                carry  = va[7];
            end
            MODE_RCR:
            begin
                kind   = KIND_SHR;
                result = {flags_in.c, va[7:1]};
                carry  = va[0];
            end
            MODE_LOADIMM: result = imm_value;
            default:      result = '0;
        endcase
    end

    always_comb
    begin
        ovf = 1'b0;
        if (kind == KIND_ADD)
        begin
            ovf = (va[7] ^ result[7]) & (y[7] ^ result[7]);
        end
        else if (kind == KIND_SUB)
        begin
            ovf = (va[7] ^ y[7]) & (va[7] ^ result[7]);
        end
    end

    always_comb
    begin
        flags_out = flags_in;
        if (mode != MODE_LOADIMM)
        begin
            if (flag_mask[0])
            begin
                flags_out.z = (result == '0);
            end
            if (flag_mask[1])
            begin
                flags_out.s = result[7];
            end
            if (flag_mask[2] && (kind != KIND_NONE))
            begin
                flags_out.c = carry;
            end
            if (flag_mask[3] && ((kind == KIND_ADD) || (kind == KIND_SUB)))
            begin
                flags_out.o = ovf;
            end
        end
    end

endmodule

// ----- rtl/alu_execute_with_flags.sv -----
// Top level of the ALU execute block: operand read stage, execute and write-back, result register.
// Takes one instruction per clock cycle unless the output side stalls. An accepted instruction
// reads its operands from the register file memory into the read-port registers at the accepting
// edge; once the output side can take it, the instruction executes, writes register A and loads
// the result register, from which the result is offered until it transfers. A back-to-back
// dependency on the register just written is served by the register file's write bypass, and
// the flags and random source sit in flip-flops, so the read-modify-write of the register file
// sets the rate of one per cycle while the output side does not stall. After reset all registers
// read as zero, all flags are clear and the random source holds 0xE1.
module alu_execute_with_flags
    import afx_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [4:0] mode,
    input  logic [2:0] reg_a,
    input  logic [2:0] reg_b,
    input  logic       two_operands,
    input  logic [3:0] flag_mask,
    input  logic [7:0] imm_value,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] result_value,
    output logic       zero_flag,
    output logic       sign_flag,
    output logic       carry_flag,
    output logic       overflow_flag
);

    logic     in_xfer;
    logic     s1_advance;
    logic     exec_fire;
    logic     s1_valid_reg;
    logic     s1_valid_next;
    logic     out_valid_reg;
    logic     out_valid_next;
    mode_t    s1_mode_reg;
    reg_idx_t s1_ia_reg;
    logic     s1_two_reg;
    mask_t    s1_mask_reg;
    data_t    s1_imm_reg;
    flags_t   flags_reg;
    data_t    lfsr_reg;
    data_t    out_result_reg;
    flags_t   out_flags_reg;
    data_t    rd_a_data;
    data_t    rd_b_data;
    data_t    vb;
    data_t    alu_result;
    flags_t   alu_flags;
    data_t    alu_lfsr;

    assign s1_advance = !out_valid_reg || !out_stall;
    assign exec_fire  = s1_valid_reg && s1_advance;
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign in_xfer    = in_valid && !in_stall;

    assign vb = s1_two_reg ? rd_b_data : '0;

    afx_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (in_xfer),
        .rd_a_idx  (reg_reduce(reg_a)),
        .rd_b_idx  (reg_reduce(reg_b)),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data),
        .wr_en     (exec_fire),
        .wr_idx    (s1_ia_reg),
        .wr_data   (alu_result)
    );

    afx_alu u_alu (
        .mode      (s1_mode_reg),
        .va        (rd_a_data),
        .vb        (vb),
        .flag_mask (s1_mask_reg),
        .imm_value (s1_imm_reg),
        .flags_in  (flags_reg),
        .lfsr_in   (lfsr_reg),
        .result    (alu_result),
        .flags_out (alu_flags),
        .lfsr_out  (alu_lfsr)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
        begin
            s1_valid_next = 1'b1;
        end
        else if (exec_fire)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = exec_fire || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
            lfsr_reg      <= LFSR_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (exec_fire)
            begin
                flags_reg <= alu_flags;
                lfsr_reg  <= alu_lfsr;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_mode_reg <= mode;
            s1_ia_reg   <= reg_reduce(reg_a);
            s1_two_reg  <= two_operands;
            s1_mask_reg <= flag_mask;
            s1_imm_reg  <= imm_value;
        end
        if (exec_fire)
        begin
            out_result_reg <= alu_result;
            out_flags_reg  <= alu_flags;
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_value  = out_result_reg;
    assign zero_flag     = out_flags_reg.z;
    assign sign_flag     = out_flags_reg.s;
    assign carry_flag    = out_flags_reg.c;
    assign overflow_flag = out_flags_reg.o;

endmodule

// ----- rtl/afx_checker.sv -----
// Port-level checker for the ALU execute block and its bind to the top level.
module afx_checker
    import afx_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [4:0] mode,
    input logic [7:0] imm_value,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] result_value,
    input logic       zero_flag,
    input logic       sign_flag,
    input logic       carry_flag,
    input logic       overflow_flag
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output transfer dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(result_value) && $stable(zero_flag)
            && $stable(sign_flag) && $stable(carry_flag) && $stable(overflow_flag))
        else $error("stalled result changed");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    a_loadimm: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && mode == MODE_LOADIMM) ##1 !out_stall
            |=> out_valid && result_value == $past(imm_value, 2))
        else $error("load immediate result mismatch");

endmodule

bind alu_execute_with_flags afx_checker u_afx_checker (.*);
